// ----- rtl/core/ifp_pkg.sv -----
// Shared types, constants and helpers for the iBUS frame parser.
package ifp_pkg;

  localparam logic [7:0]  HDR_FIRST  = 8'h20;
  localparam logic [7:0]  HDR_SECOND = 8'h40;
  localparam logic [15:0] SUM_INIT   = 16'hFFFF;
  localparam logic [15:0] PITCH_BASE = 16'd3000;

  localparam logic [4:0] POS_HDR_FIRST  = 5'd0;
  localparam logic [4:0] POS_HDR_SECOND = 5'd1;
  localparam logic [4:0] POS_FIRST_WORD = 5'd2;
  localparam logic [4:0] POS_TRAILER_LO = 5'd30;

  localparam logic [2:0] ST_BYTE_TAKEN  = 3'd0;
  localparam logic [2:0] ST_BAD_HEADER  = 3'd1;
  localparam logic [2:0] ST_ACCEPTED    = 3'd2;
  localparam logic [2:0] ST_CSUM_ERROR  = 3'd3;
  localparam logic [2:0] ST_RANGE_ERROR = 3'd4;

  localparam logic [2:0] CFG_CHANNEL_MIN  = 3'd0;
  localparam logic [2:0] CFG_CHANNEL_MAX  = 3'd1;
  localparam logic [2:0] CFG_SWITCH_LOW   = 3'd2;
  localparam logic [2:0] CFG_SWITCH_HIGH  = 3'd3;
  localparam logic [2:0] CFG_DEBOUNCE     = 3'd4;

  localparam int NUM_SLOTS = 7;

  typedef struct packed {
    logic [11:0] low_level;
    logic [11:0] high_level;
    logic [3:0]  frames;
  } sw_cfg_t;

  typedef struct packed {
    logic position;
    logic changed;
    logic glitch;
  } sw_res_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] roll;
    logic [11:0] pitch;
    logic [11:0] throttle;
    logic [11:0] yaw;
    logic        arm_position;
    logic        mode_position;
    logic        hold_position;
    logic [2:0]  switch_changed;
    logic [1:0]  glitch_count;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] slot;
  } slot_t;

  // High-byte position to channel slot
  function automatic slot_t slot_of(input logic [4:0] pos);
    slot_t s;
    s.valid = 1'b1;
    s.slot  = 3'd0;
    case (pos)
      5'd3:    s.slot = 3'd0;
      5'd5:    s.slot = 3'd1;
      5'd7:    s.slot = 3'd2;
      5'd9:    s.slot = 3'd3;
      5'd11:   s.slot = 3'd4;
      5'd13:   s.slot = 3'd5;
      5'd17:   s.slot = 3'd6;
      default: s.valid = 1'b0;
    endcase
    return s;
  endfunction

  function automatic logic in_range(input logic [15:0] v, input logic [11:0] lo,
                                    input logic [11:0] hi);
    return (v >= {4'd0, lo}) && (v <= {4'd0, hi});
  endfunction

endpackage

// ----- rtl/core/ifp_switch_debounce.sv -----
// Hysteresis and frame-count debounce for one switch channel.
module ifp_switch_debounce (
  input  logic            clk,
  input  logic            rst,
  input  logic            update,
  input  logic [15:0]     raw,
  input  ifp_pkg::sw_cfg_t cfg,
  output ifp_pkg::sw_res_t res
);
  import ifp_pkg::*;

  logic       stable, stable_next;
  logic       candidate, candidate_next;
  logic [3:0] frames, frames_next;
  logic       norm;
  logic [3:0] frames_inc;

  always_comb begin
    if (raw >= {4'd0, cfg.high_level}) begin
      norm = 1'b1;
    end else if (raw <= {4'd0, cfg.low_level}) begin
      norm = 1'b0;
    end else begin
      norm = stable;
    end
    frames_inc = (frames < cfg.frames) ? frames + 4'd1 : frames;

    stable_next    = stable;
    candidate_next = candidate;
    frames_next    = frames;
    res.changed    = 1'b0;
    res.glitch     = 1'b0;
    if (update) begin
      if (norm == stable) begin
        candidate_next = norm;
        frames_next    = 4'd0;
      end else if (norm != candidate) begin
        candidate_next = norm;
        frames_next    = 4'd1;
        res.glitch     = 1'b1;
      end else if (frames_inc < cfg.frames) begin
        frames_next = frames_inc;
        res.glitch  = 1'b1;
      end else begin
        stable_next = norm;
        frames_next = 4'd0;
        res.changed = 1'b1;
      end
    end
    res.position = stable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable    <= 1'b0;
      candidate <= 1'b0;
      frames    <= 4'd0;
    end else begin
      stable    <= stable_next;
      candidate <= candidate_next;
      frames    <= frames_next;
    end
  end

  a_change_flips: assert property (@(posedge clk) disable iff (rst)
    res.changed |=> stable != $past(stable))
    else $error("reported change without a position flip");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !update |=> $stable(stable) && $stable(frames))
    else $error("debounce state moved without a frame");

endmodule

// ----- rtl/core/ifp_result_queue.sv -----
// Two-entry result buffer between the parser and the output channel.
module ifp_result_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ifp_pkg::result_t push_data,
  output logic             full,
  input  logic             pop_ready,
  output logic             head_valid,
  output ifp_pkg::result_t head
);
  import ifp_pkg::*;

  logic [1:0] count;
  result_t    slot0, slot1;
  logic       pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot0;
  assign pop        = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end else if (pop && !push) begin
      slot0 <= slot1;
    end else if (pop && push) begin
      slot0 <= push_data;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !pop_ready) |=> head_valid && $stable(head))
    else $error("waiting result changed or vanished");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

endmodule

// ----- rtl/core/ibus_frame_parser_debounce_top.sv -----
// Top level: iBUS byte framing, checksum, range check and switch debounce.
// One received byte is taken per clock while the result buffer has room, and
// gives exactly one result transfer; the running 16-bit checksum subtract
// and the latched channel words let each byte finish as it is accepted. Results
// pass through a two-entry buffer, so bytes keep flowing at one per cycle
// while a result waits, and input stalls only when both entries are held.
// Each result is registered in the buffer as its byte is taken. Configuration
// writes take effect on the next clock; write only when no transfer is in flight.
module ibus_frame_parser_debounce_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        abort_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [11:0] roll,
  output logic [11:0] pitch,
  output logic [11:0] throttle,
  output logic [11:0] yaw,
  output logic        arm_position,
  output logic        mode_position,
  output logic        hold_position,
  output logic [2:0]  switch_changed,
  output logic [1:0]  glitch_count
);
  import ifp_pkg::*;

  logic [11:0] channel_min, channel_max, switch_low_level, switch_high_level;
  logic [3:0]  debounce_frames;

  logic [4:0]  byte_pos, byte_pos_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  low_byte_hold, low_byte_hold_next;
  logic [7:0]  trailer_low, trailer_low_next;
  logic [15:0] channel_store [NUM_SLOTS];

  logic        accept, q_full;
  logic [2:0]  res_status;
  logic        frame_good;
  logic        store_we;
  slot_t       slot;
  logic [15:0] pitch_word;
  logic        ranges_ok;
  sw_cfg_t     sw_cfg;
  sw_res_t     arm_res, mode_res, hold_res;
  result_t     res, head;

  assign accept   = in_valid && in_ready;
  assign in_ready = !q_full;
  assign slot     = slot_of(byte_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_min       <= 12'd900;
      channel_max       <= 12'd2100;
      switch_low_level  <= 12'd1300;
      switch_high_level <= 12'd1700;
      debounce_frames   <= 4'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNEL_MIN: channel_min       <= cfg_data;
        CFG_CHANNEL_MAX: channel_max       <= cfg_data;
        CFG_SWITCH_LOW:  switch_low_level  <= cfg_data;
        CFG_SWITCH_HIGH: switch_high_level <= cfg_data;
        CFG_DEBOUNCE:    debounce_frames   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign pitch_word = PITCH_BASE - channel_store[1];
  assign ranges_ok  = (channel_store[1] <= PITCH_BASE)
                   && in_range(channel_store[0], channel_min, channel_max)
                   && in_range(pitch_word, channel_min, channel_max)
                   && in_range(channel_store[2], channel_min, channel_max)
                   && in_range(channel_store[3], channel_min, channel_max)
                   && in_range(channel_store[4], channel_min, channel_max)
                   && in_range(channel_store[5], channel_min, channel_max)
                   && in_range(channel_store[6], channel_min, channel_max);

  always_comb begin
    byte_pos_next      = byte_pos;
    running_sum_next   = running_sum;
    low_byte_hold_next = low_byte_hold;
    trailer_low_next   = trailer_low;
    store_we           = 1'b0;
    res_status         = ST_BYTE_TAKEN;
    frame_good         = 1'b0;
    if (abort_frame) begin
      byte_pos_next    = POS_HDR_FIRST;
      running_sum_next = SUM_INIT;
    end else if (byte_pos == POS_HDR_FIRST) begin
      if (data_byte == HDR_FIRST) begin
        running_sum_next = SUM_INIT - {8'd0, HDR_FIRST};
        byte_pos_next    = POS_HDR_SECOND;
      end else begin
        res_status = ST_BAD_HEADER;
      end
    end else if (byte_pos == POS_HDR_SECOND) begin
      if (data_byte == HDR_SECOND) begin
        running_sum_next = running_sum - {8'd0, data_byte};
        byte_pos_next    = POS_FIRST_WORD;
      end else begin
        res_status = ST_BAD_HEADER;
        if (data_byte == HDR_FIRST) begin
          running_sum_next = SUM_INIT - {8'd0, HDR_FIRST};
          byte_pos_next    = POS_HDR_SECOND;
        end else begin
          byte_pos_next = POS_HDR_FIRST;
        end
      end
    end else if (byte_pos < POS_TRAILER_LO) begin
      running_sum_next = running_sum - {8'd0, data_byte};
      if (!byte_pos[0]) begin
        low_byte_hold_next = data_byte;
      end else begin
        store_we = slot.valid;
      end
      byte_pos_next = byte_pos + 5'd1;
    end else if (byte_pos == POS_TRAILER_LO) begin
      trailer_low_next = data_byte;
      byte_pos_next    = byte_pos + 5'd1;
    end else begin
      byte_pos_next = POS_HDR_FIRST;
      if ({data_byte, trailer_low} != running_sum) begin
        res_status = ST_CSUM_ERROR;
      end else if (!ranges_ok) begin
        res_status = ST_RANGE_ERROR;
      end else begin
        res_status = ST_ACCEPTED;
        frame_good = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos      <= POS_HDR_FIRST;
      running_sum   <= SUM_INIT;
      low_byte_hold <= 8'd0;
      trailer_low   <= 8'd0;
    end else if (accept) begin
      byte_pos      <= byte_pos_next;
      running_sum   <= running_sum_next;
      low_byte_hold <= low_byte_hold_next;
      trailer_low   <= trailer_low_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) begin
      channel_store[slot.slot] <= {data_byte, low_byte_hold};
    end
  end

  assign sw_cfg.low_level  = switch_low_level;
  assign sw_cfg.high_level = switch_high_level;
  assign sw_cfg.frames     = debounce_frames;

  ifp_switch_debounce u_arm (
    .clk(clk), .rst(rst), .update(accept && frame_good),
    .raw(channel_store[4]), .cfg(sw_cfg), .res(arm_res)
  );

  ifp_switch_debounce u_mode (
    .clk(clk), .rst(rst), .update(accept && frame_good),
    .raw(channel_store[5]), .cfg(sw_cfg), .res(mode_res)
  );

  ifp_switch_debounce u_hold (
    .clk(clk), .rst(rst), .update(accept && frame_good),
    .raw(channel_store[6]), .cfg(sw_cfg), .res(hold_res)
  );

  always_comb begin
    res.status         = res_status;
    res.roll           = frame_good ? channel_store[0][11:0] : 12'd0;
    res.pitch          = frame_good ? pitch_word[11:0] : 12'd0;
    res.throttle       = frame_good ? channel_store[2][11:0] : 12'd0;
    res.yaw            = frame_good ? channel_store[3][11:0] : 12'd0;
    res.arm_position   = arm_res.position;
    res.mode_position  = mode_res.position;
    res.hold_position  = hold_res.position;
    res.switch_changed = {hold_res.changed, mode_res.changed, arm_res.changed};
    res.glitch_count   = {1'b0, arm_res.glitch} + {1'b0, mode_res.glitch}
                       + {1'b0, hold_res.glitch};
  end

  ifp_result_queue u_queue (
    .clk(clk), .rst(rst), .push(accept), .push_data(res), .full(q_full),
    .pop_ready(out_ready), .head_valid(out_valid), .head(head)
  );

  assign status         = head.status;
  assign roll           = head.roll;
  assign pitch          = head.pitch;
  assign throttle       = head.throttle;
  assign yaw            = head.yaw;
  assign arm_position   = head.arm_position;
  assign mode_position  = head.mode_position;
  assign hold_position  = head.hold_position;
  assign switch_changed = head.switch_changed;
  assign glitch_count   = head.glitch_count;

  a_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_ACCEPTED) |->
      (roll == 12'd0 && pitch == 12'd0 && throttle == 12'd0 && yaw == 12'd0
       && switch_changed == 3'd0 && glitch_count == 2'd0))
    else $error("channel fields set on a non-accepted result");

  a_abort_resets: assert property (@(posedge clk) disable iff (rst)
    (accept && abort_frame) |=> byte_pos == POS_HDR_FIRST && running_sum == SUM_INIT)
    else $error("abort did not drop the partial frame");

  a_good_at_end: assert property (@(posedge clk) disable iff (rst)
    frame_good |-> byte_pos == 5'd31)
    else $error("frame accepted away from the trailer");

endmodule
